// ----- rtl/lpt_pkg.sv -----
// Shared constants, codes and controller/datapath handshake types for the positional list table.
`timescale 1ns / 1ps

package lpt_pkg;

   // Fixed field widths of the channels
   localparam int CMD_W   = 2;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 7;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEFAULT   = 64;
   localparam int ITEM_WIDTH_DEFAULT = 32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture a request and decode it
      logic step;    // issue one shift read
      logic fetch;   // read the addressed entry for a retrieve
      logic commit;  // update the list and load the result register
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rem_zero;  // no shift reads left
      logic rsp_busy;  // result register still holds an untaken result
   } ctl_status_type;

endpackage

// ----- rtl/lpt_req_if.sv -----
// Request and response channel interfaces of the positional list table.
`timescale 1ns / 1ps

interface lpt_req_if;
   logic                           valid;
   logic                           ready;
   logic [lpt_pkg::CMD_W-1:0]      command;
   logic [lpt_pkg::POS_W-1:0]      position;
   logic [lpt_pkg::VALUE_W-1:0]    item_value;

   modport source (output valid, output command, output position, output item_value,
                   input ready);
   modport sink   (input valid, input command, input position, input item_value,
                   output ready);
endinterface

interface lpt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpt_pkg::STAT_W-1:0]     status;
   logic [lpt_pkg::VALUE_W-1:0]    read_value;
   logic [lpt_pkg::LEN_W-1:0]      length;
   logic                           is_empty;

   modport source (output valid, output status, output read_value, output length,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input read_value, input length,
                   input is_empty, output ready);
endinterface

// ----- rtl/lpt_ctrl.sv -----
// Controller state machine of the positional list table.
`timescale 1ns / 1ps

module lpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lpt_pkg::ctl_status_type dp_status,
   output lpt_pkg::ctl_cmd_type    dp_cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SHIFT  = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      dp_cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
            if (req_valid) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            dp_cmd.step = !dp_status.rem_zero;
            if (dp_status.rem_zero) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // last shift write is already in memory; retrieve read goes out
            dp_cmd.fetch = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register is free
            dp_cmd.commit = !dp_status.rsp_busy;
            if (!dp_status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lpt_datapath.sv -----
// Datapath of the positional list table: entry memory, length counter, shift pointer, result register.
`timescale 1ns / 1ps

module lpt_datapath #(
   parameter int CAPACITY   = lpt_pkg::CAPACITY_DEFAULT,
   parameter int ITEM_WIDTH = lpt_pkg::ITEM_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lpt_pkg::ctl_cmd_type         dp_cmd,
   output lpt_pkg::ctl_status_type      dp_status,
   input  logic [lpt_pkg::CMD_W-1:0]    req_command,
   input  logic [lpt_pkg::POS_W-1:0]    req_position,
   input  logic [lpt_pkg::VALUE_W-1:0]  req_item_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lpt_pkg::STAT_W-1:0]   rsp_status,
   output logic [lpt_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [lpt_pkg::LEN_W-1:0]    rsp_length,
   output logic                         rsp_is_empty
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > lpt_pkg::POS_W) ? CNT_W : lpt_pkg::POS_W) + 1;

   logic [ITEM_WIDTH-1:0] entry_mem [CAPACITY];

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rem_ff;
   logic [AW-1:0]             ptr_ff;
   logic [AW-1:0]             slot_ff;
   logic [AW-1:0]             wr_addr_ff;
   logic                      wr_vld_ff;
   logic [ITEM_WIDTH-1:0]     item_ff;
   logic [ITEM_WIDTH-1:0]     rd_data_ff;
   logic [lpt_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic                      ins_ok_ff, rem_ok_ff, get_ok_ff;
   logic                      ins_ok_in, rem_ok_in, get_ok_in;

   logic                      rsp_valid_ff;
   logic [lpt_pkg::STAT_W-1:0] rsp_status_ff;
   logic [lpt_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [lpt_pkg::LEN_W-1:0] rsp_length_ff;
   logic                      rsp_empty_ff;

   // Request decode
   logic [CMP_W-1:0]          pos_w, cnt_w, slot_w;
   logic [CMP_W-1:0]          rem_w, ptr_w;
   logic                      pos_zero, ins_bad, rr_bad, is_full;
   logic [ITEM_WIDTH+lpt_pkg::VALUE_W-1:0] item_ext;
   logic [ITEM_WIDTH+lpt_pkg::VALUE_W-1:0] rd_ext;
   logic [CNT_W+lpt_pkg::LEN_W-1:0]        len_ext;

   always_comb begin
      pos_w     = CMP_W'(req_position);
      cnt_w     = CMP_W'(count_ff);
      slot_w    = pos_w - CMP_W'(1);
      pos_zero  = (req_position == '0);
      ins_bad   = pos_zero || (pos_w > cnt_w + CMP_W'(1));
      rr_bad    = pos_zero || (pos_w > cnt_w);
      is_full   = (count_ff == CNT_W'(CAPACITY));
      stat_in   = lpt_pkg::STAT_BAD_POS;
      ins_ok_in = 1'b0;
      rem_ok_in = 1'b0;
      get_ok_in = 1'b0;
      rem_w     = '0;
      ptr_w     = '0;
      case (req_command)
         lpt_pkg::CMD_INSERT: begin
            if (!ins_bad) begin
               if (is_full) begin
                  stat_in = lpt_pkg::STAT_FULL;
               end else begin
                  stat_in   = lpt_pkg::STAT_OK;
                  ins_ok_in = 1'b1;
                  rem_w     = cnt_w - slot_w;
                  ptr_w     = cnt_w - CMP_W'(1);
               end
            end
         end
         lpt_pkg::CMD_REMOVE: begin
            if (!rr_bad) begin
               stat_in   = lpt_pkg::STAT_OK;
               rem_ok_in = 1'b1;
               rem_w     = cnt_w - slot_w - CMP_W'(1);
               ptr_w     = slot_w + CMP_W'(1);
            end
         end
         lpt_pkg::CMD_RETRIEVE: begin
            if (!rr_bad) begin
               stat_in   = lpt_pkg::STAT_OK;
               get_ok_in = 1'b1;
            end
         end
         default: stat_in = lpt_pkg::STAT_BAD_POS;
      endcase
   end

   assign item_ext = {{ITEM_WIDTH{1'b0}}, req_item_value};

   // Sequencing registers
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         stat_ff   <= stat_in;
         ins_ok_ff <= ins_ok_in;
         rem_ok_ff <= rem_ok_in;
         get_ok_ff <= get_ok_in;
         slot_ff   <= slot_w[AW-1:0];
         item_ff   <= item_ext[ITEM_WIDTH-1:0];
      end
      if (dp_cmd.load) begin
         rem_ff <= rem_w[CNT_W-1:0];
         ptr_ff <= ptr_w[AW-1:0];
      end else if (dp_cmd.step) begin
         rem_ff <= rem_ff - CNT_W'(1);
         ptr_ff <= ins_ok_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
      end
      // a shift read lands one slot up for insert, one down for remove
      wr_addr_ff <= ins_ok_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= dp_cmd.step;
      end
   end

   // Entry memory: one write and one read port, registered read
   always_ff @(posedge clock) begin
      if (wr_vld_ff) begin
         entry_mem[wr_addr_ff] <= rd_data_ff;
      end else if (dp_cmd.commit && ins_ok_ff) begin
         entry_mem[slot_ff] <= item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.step) begin
         rd_data_ff <= entry_mem[ptr_ff];
      end else if (dp_cmd.fetch) begin
         rd_data_ff <= entry_mem[slot_ff];
      end
   end

   // Length counter and result register
   always_comb begin
      count_in = count_ff;
      if (ins_ok_ff) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ok_ff) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign len_ext = {{lpt_pkg::LEN_W{1'b0}}, count_in};
   assign rd_ext  = {{lpt_pkg::VALUE_W{1'b0}}, rd_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_status_ff <= stat_ff;
         rsp_value_ff  <= get_ok_ff ? rd_ext[lpt_pkg::VALUE_W-1:0] : '0;
         rsp_length_ff <= len_ext[lpt_pkg::LEN_W-1:0];
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign dp_status.rem_zero = (rem_ff == '0);
   assign dp_status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

// ----- rtl/positional_list_table_top.sv -----
// Top level of the positional list table: controller, datapath and channel hookup.
//
// Ordered list of up to CAPACITY entries addressed by 1-based position.
// req_ch carries command (insert, remove, retrieve), position and item_value;
// rsp_ch returns one result per request: status, read_value, length, is_empty.
// Both channels transfer on a clock edge with valid and ready high.
// One request is worked at a time. An insert or remove moves k entries, where
// k is the number of entries from the addressed position on for an insert, or
// after it for a remove (up to CAPACITY - 1); each move is one read and one
// write of the single-port-pair entry memory, pipelined at one entry per cycle.
// The result is loaded into the output register in the commit step, after the
// shift and finish steps; the next request can transfer once the controller is
// back in idle. Bad positions, full inserts and retrieves move no entries.
// A new request is taken while a finished result still waits in the output
// register; when rsp_ch stalls, the next request is worked up to its commit
// step and held there until the result register frees up.
// Synchronous reset empties the list and drops any pending result; the
// entry memory itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module positional_list_table_top #(
   parameter int CAPACITY   = lpt_pkg::CAPACITY_DEFAULT,
   parameter int ITEM_WIDTH = lpt_pkg::ITEM_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lpt_req_if.sink    req_ch,
   lpt_rsp_if.source  rsp_ch
);

   lpt_pkg::ctl_cmd_type    dp_cmd;
   lpt_pkg::ctl_status_type dp_status;

   lpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   lpt_datapath #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_command    (req_ch.command),
      .req_position   (req_ch.position),
      .req_item_value (req_ch.item_value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_status     (rsp_ch.status),
      .rsp_read_value (rsp_ch.read_value),
      .rsp_length     (rsp_ch.length),
      .rsp_is_empty   (rsp_ch.is_empty)
   );

endmodule

// ----- bench/positional_list_table_top_test.sv -----
// Self-checking bench for the positional list table: directed table, then phased random traffic.
`timescale 1ns / 1ps

module positional_list_table_top_test;

   localparam int CMD_W       = lpt_pkg::CMD_W;
   localparam int POS_W       = lpt_pkg::POS_W;
   localparam int VALUE_W     = lpt_pkg::VALUE_W;
   localparam int STAT_W      = lpt_pkg::STAT_W;
   localparam int LEN_W       = lpt_pkg::LEN_W;
   localparam int CAP         = lpt_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_OPS  = 650;
   localparam int DRAIN_WAIT  = CAP + 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   // command code with no operation behind it
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] item_value;
   } list_op_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] read_value;
      logic [LEN_W-1:0]   length;
      logic               is_empty;
   } list_rsp_type;

   typedef struct packed {
      list_op_type  op;
      logic         has_lit;
      list_rsp_type lit;
   } dir_row_type;

   typedef enum {FILL_MODE, DRAIN_MODE, MIX_MODE} list_mode_type;

   logic clock = 1'b0;
   logic reset;

   lpt_req_if req_ch ();
   lpt_rsp_if rsp_ch ();

   positional_list_table_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // shadow copy of the list, advanced once per accepted request
   logic [VALUE_W-1:0] list_mem [CAP];
   int                 list_len;

   list_rsp_type pending_results [$];
   int           fail_count  = 0;
   int           items_sent  = 0;
   int           cycle_count = 0;

   function automatic list_rsp_type list_apply(list_op_type op);
      list_rsp_type r;
      int           p;
      r = '0;
      r.status = lpt_pkg::STAT_BAD_POS;
      p = int'(op.position);
      case (op.command)
         lpt_pkg::CMD_INSERT: begin
            if (p >= 1 && p <= list_len + 1) begin
               if (list_len >= CAP) begin
                  r.status = lpt_pkg::STAT_FULL;
               end else begin
                  for (int i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
                  list_mem[p-1] = op.item_value;
                  list_len++;
                  r.status = lpt_pkg::STAT_OK;
               end
            end
         end
         lpt_pkg::CMD_REMOVE: begin
            if (p >= 1 && p <= list_len) begin
               for (int i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
               r.status = lpt_pkg::STAT_OK;
            end
         end
         lpt_pkg::CMD_RETRIEVE: begin
            if (p >= 1 && p <= list_len) begin
               r.status = lpt_pkg::STAT_OK;
               r.read_value = list_mem[p-1];
            end
         end
         default: r.status = lpt_pkg::STAT_BAD_POS;
      endcase
      r.length = LEN_W'(list_len);
      r.is_empty = (list_len == 0);
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic list_op_type pick_op(list_mode_type mode);
      list_op_type op;
      int          r;
      int          ins_w;
      int          rem_w;
      op.item_value = pick_value();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // noise: any command, any position in range
         op.command = CMD_W'($urandom_range(0, 3));
         op.position = POS_W'($urandom_range(0, 65));
         return op;
      end
      case (mode)
         FILL_MODE: begin
            ins_w = 75;
            rem_w = 10;
         end
         DRAIN_MODE: begin
            ins_w = 10;
            rem_w = 75;
         end
         default: begin
            ins_w = 35;
            rem_w = 30;
         end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_w) begin
         op.command = lpt_pkg::CMD_INSERT;
         op.position = POS_W'($urandom_range(1, list_len + 1));
      end else begin
         op.command = (r < ins_w + rem_w) ? lpt_pkg::CMD_REMOVE : lpt_pkg::CMD_RETRIEVE;
         op.position = POS_W'((list_len == 0) ? 1 : $urandom_range(1, list_len));
      end
      return op;
   endfunction

   function automatic dir_row_type row(logic [CMD_W-1:0] cmd, int pos, logic [VALUE_W-1:0] val,
                                       bit lit, logic [STAT_W-1:0] st = lpt_pkg::STAT_OK,
                                       logic [VALUE_W-1:0] rv = '0, int len = 0,
                                       bit emp = 1'b0);
      dir_row_type d;
      d.op.command = cmd;
      d.op.position = POS_W'(pos);
      d.op.item_value = val;
      d.has_lit = lit;
      d.lit.status = st;
      d.lit.read_value = rv;
      d.lit.length = LEN_W'(len);
      d.lit.is_empty = emp;
      return d;
   endfunction

   task automatic send_op(list_op_type op, bit use_lit, list_rsp_type lit, bit calm);
      int           gap;
      list_rsp_type predicted;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= op.command;
      req_ch.position   <= op.position;
      req_ch.item_value <= op.item_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = list_apply(op);
      pending_results.push_back(use_lit ? lit : predicted);
      items_sent++;
   endtask

   // request side: directed table, then fill / drain / mixed phases
   initial begin
      dir_row_type   dir_table [$];
      list_mode_type mode;
      int            random_count;
      int            extra;
      int            span;
      bit            calm;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= lpt_pkg::CMD_INSERT;
      req_ch.position   <= '0;
      req_ch.item_value <= '0;
      list_len = 0;
      for (int i = 0; i < CAP; i++) list_mem[i] = '0;

      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 1, 32'h0, 1, lpt_pkg::STAT_BAD_POS,
                              0, 0, 1));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 1, 32'h0, 1, lpt_pkg::STAT_BAD_POS,
                              0, 0, 1));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 0, 32'h1234, 1, lpt_pkg::STAT_BAD_POS,
                              0, 0, 1));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 2, 32'h1234, 1, lpt_pkg::STAT_BAD_POS,
                              0, 0, 1));
      dir_table.push_back(row(CMD_SPARE, 1, 32'h0, 1, lpt_pkg::STAT_BAD_POS, 0, 0, 1));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 1, 32'hFFFF_FFFF, 1, lpt_pkg::STAT_OK,
                              0, 1, 0));
      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 1, 32'h0, 1, lpt_pkg::STAT_OK,
                              32'hFFFF_FFFF, 1, 0));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 1, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 3, 32'hA5A5_A5A5, 0));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 2, 32'h5A5A_5A5A, 0));
      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 1, 32'hDEAD_BEEF, 0));
      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 2, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 4, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 5, 32'h0, 1, lpt_pkg::STAT_BAD_POS,
                              0, 4, 0));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 0, 32'h0, 1, lpt_pkg::STAT_BAD_POS,
                              0, 4, 0));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 6, 32'h7, 1, lpt_pkg::STAT_BAD_POS,
                              0, 4, 0));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 65, 32'h7, 1, lpt_pkg::STAT_BAD_POS,
                              0, 4, 0));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 2, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_RETRIEVE, 2, 32'h0, 0));
      dir_table.push_back(row(CMD_SPARE, 2, 32'hFFFF_FFFF, 1, lpt_pkg::STAT_BAD_POS,
                              0, 3, 0));
      dir_table.push_back(row(lpt_pkg::CMD_INSERT, 4, 32'h8000_0001, 0));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 4, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 1, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 1, 32'h0, 0));
      dir_table.push_back(row(lpt_pkg::CMD_REMOVE, 1, 32'h0, 1, lpt_pkg::STAT_OK,
                              0, 0, 1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[k]) send_op(dir_table[k].op, dir_table[k].has_lit, dir_table[k].lit, 0);

      random_count = 0;
      mode = FILL_MODE;
      while (random_count < RANDOM_OPS) begin
         calm = ($urandom_range(0, 3) == 0);
         case (mode)
            FILL_MODE: begin
               // run to a full list, then keep knocking on it
               extra = $urandom_range(4, 12);
               while ((list_len < CAP || extra > 0) && random_count < RANDOM_OPS) begin
                  if (list_len == CAP) extra--;
                  send_op(pick_op(mode), 0, '0, calm);
                  random_count++;
               end
               mode = DRAIN_MODE;
            end
            DRAIN_MODE: begin
               extra = $urandom_range(4, 12);
               while ((list_len > 0 || extra > 0) && random_count < RANDOM_OPS) begin
                  if (list_len == 0) extra--;
                  send_op(pick_op(mode), 0, '0, calm);
                  random_count++;
               end
               mode = MIX_MODE;
            end
            default: begin
               span = $urandom_range(30, 60);
               while (span > 0 && random_count < RANDOM_OPS) begin
                  span--;
                  send_op(pick_op(mode), 0, '0, calm);
                  random_count++;
               end
               mode = FILL_MODE;
            end
         endcase
      end
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // result side: random stalls, calm runs, and one long hold-off to back up the block
   initial begin
      bit hold_pending;
      int stall;
      hold_pending = 1'b1;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_pending && items_sent >= 150) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else begin
            stall = idle_len();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_ch.read_value);
               fail_count++;
            end
            if (rsp_ch.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_ch.length);
               fail_count++;
            end
            if (rsp_ch.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
rtl/lpt_pkg.sv
rtl/lpt_req_if.sv
rtl/lpt_ctrl.sv
rtl/lpt_datapath.sv
rtl/positional_list_table_top.sv
bench/positional_list_table_top_test.sv
